// ----- hw/rtl/cdd_pkg.sv -----
`timescale 1ns / 1ps
package cdd_pkg;
	typedef enum logic [12:0] {
		PH_FLAG    = 13'b0000000000001,
		PH_VER     = 13'b0000000000010,
		PH_NLEN_HI = 13'b0000000000100,
		PH_NLEN_LO = 13'b0000000001000,
		PH_NAME    = 13'b0000000010000,
		PH_MLEN_HI = 13'b0000000100000,
		PH_MLEN_LO = 13'b0000001000000,
		PH_MSG     = 13'b0000010000000,
		PH_V1_DONE = 13'b0000100000000,
		PH_V2_NAME = 13'b0001000000000,
		PH_V2_MSG  = 13'b0010000000000,
		PH_V2_DONE = 13'b0100000000000,
		PH_ERR     = 13'b1000000000000
	} phase_t;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_TRUNC = 3'd1;
	localparam logic [2:0] ST_FLAG  = 3'd2;
	localparam logic [2:0] ST_VER   = 3'd3;
	localparam logic [2:0] ST_TRAIL = 3'd4;
	localparam logic [2:0] ST_NL    = 3'd5;
	localparam logic [2:0] ST_B64   = 3'd6;
	localparam logic [2:0] ST_EMPTY = 3'd7;

	localparam logic [7:0] FLAG_BYTE = 8'h01;
	localparam logic [7:0] VER_ONE   = 8'h01;
	localparam logic [7:0] VER_TWO   = 8'h02;
	localparam logic [7:0] NEWLINE   = 8'h0A;
	localparam logic [6:0] B64_PAD   = 7'd64;
	localparam logic [6:0] B64_BAD   = 7'd127;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] dbyte;
		logic       sel;
		logic       has_verdict;
		logic [1:0] version;
		logic [2:0] status;
	} slot_t;

	function automatic logic [6:0] b64_value(input logic [7:0] c);
		logic [6:0] v;
		v = B64_BAD;
		if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
		else if (c == 8'h2B) v = 7'd62;
		else if (c == 8'h2F) v = 7'd63;
		else if (c == 8'h3D) v = B64_PAD;
		return v;
	endfunction
endpackage

// ----- hw/rtl/cdd_front.sv -----
`timescale 1ns / 1ps
module cdd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	output cdd_pkg::slot_t slot
);
	cdd_pkg::phase_t phase_q, ph;
	logic [15:0] rem_q, rem;
	logic [1:0]  ver_q, ver;
	logic [1:0]  pos_q, pos;
	logic [5:0]  carry_q, carry;
	logic        pad_q, pad, ne_q, ne;
	logic [2:0]  err_q, err;
	logic [6:0]  v;
	logic        emit, sel;
	logic [7:0]  dec;
	logic [2:0]  st;

	always_comb begin
		ph = phase_q; rem = rem_q; ver = ver_q; pos = pos_q; carry = carry_q;
		pad = pad_q; ne = ne_q; err = err_q;
		emit = 1'b0; dec = in_byte; sel = 1'b0;
		v = cdd_pkg::b64_value(in_byte);
		unique case (phase_q)
			cdd_pkg::PH_FLAG: begin
				if (in_byte != cdd_pkg::FLAG_BYTE) begin
					err = cdd_pkg::ST_FLAG; ph = cdd_pkg::PH_ERR;
				end else ph = cdd_pkg::PH_VER;
			end
			cdd_pkg::PH_VER: begin
				if (in_byte == cdd_pkg::VER_ONE) begin
					ver = 2'd1; ph = cdd_pkg::PH_NLEN_HI;
				end else if (in_byte == cdd_pkg::VER_TWO) begin
					ver = 2'd2; ph = cdd_pkg::PH_V2_NAME;
					pos = '0; carry = '0; pad = 1'b0; ne = 1'b0;
				end else begin
					err = cdd_pkg::ST_VER; ph = cdd_pkg::PH_ERR;
				end
			end
			cdd_pkg::PH_NLEN_HI, cdd_pkg::PH_MLEN_HI: begin
				rem = {in_byte, 8'h00};
				ph = (phase_q == cdd_pkg::PH_NLEN_HI) ? cdd_pkg::PH_NLEN_LO
					: cdd_pkg::PH_MLEN_LO;
			end
			cdd_pkg::PH_NLEN_LO, cdd_pkg::PH_MLEN_LO: begin
				rem = {rem_q[15:8], in_byte};
				if (phase_q == cdd_pkg::PH_NLEN_LO)
					ph = (rem != '0) ? cdd_pkg::PH_NAME : cdd_pkg::PH_MLEN_HI;
				else
					ph = (rem != '0) ? cdd_pkg::PH_MSG : cdd_pkg::PH_V1_DONE;
			end
			cdd_pkg::PH_NAME, cdd_pkg::PH_MSG: begin
				emit = 1'b1;
				sel = (phase_q == cdd_pkg::PH_MSG);
				rem = rem_q - 16'd1;
				if (rem == '0)
					ph = sel ? cdd_pkg::PH_V1_DONE : cdd_pkg::PH_MLEN_HI;
			end
			cdd_pkg::PH_V1_DONE, cdd_pkg::PH_V2_DONE: begin
				err = cdd_pkg::ST_TRAIL; ph = cdd_pkg::PH_ERR;
			end
			cdd_pkg::PH_V2_NAME, cdd_pkg::PH_V2_MSG: begin
				sel = (phase_q == cdd_pkg::PH_V2_MSG);
				if (in_byte == cdd_pkg::NEWLINE) begin
					if (pos_q != 2'd0) begin
						err = cdd_pkg::ST_B64; ph = cdd_pkg::PH_ERR;
					end else if (!ne_q) begin
						err = cdd_pkg::ST_EMPTY; ph = cdd_pkg::PH_ERR;
					end else begin
						ph = sel ? cdd_pkg::PH_V2_DONE : cdd_pkg::PH_V2_MSG;
						pos = '0; carry = '0; pad = 1'b0; ne = 1'b0;
					end
				end else if (v == cdd_pkg::B64_BAD) begin
					err = cdd_pkg::ST_B64; ph = cdd_pkg::PH_ERR;
				end else if (pad_q) begin
					if (pos_q == 2'd0 || v != cdd_pkg::B64_PAD) begin
						err = cdd_pkg::ST_B64; ph = cdd_pkg::PH_ERR;
					end else pos = pos_q + 2'd1;
				end else if (v == cdd_pkg::B64_PAD) begin
					if (pos_q < 2'd2) begin
						err = cdd_pkg::ST_B64; ph = cdd_pkg::PH_ERR;
					end else begin
						pad = 1'b1; pos = pos_q + 2'd1;
					end
				end else begin
					unique case (pos_q)
						2'd0: begin carry = v[5:0]; pos = 2'd1; end
						2'd1: begin
							dec = {carry_q[5:0], v[5:4]}; carry = {2'b00, v[3:0]};
							pos = 2'd2; emit = 1'b1; ne = 1'b1;
						end
						2'd2: begin
							dec = {carry_q[3:0], v[5:2]}; carry = {4'b0, v[1:0]};
							pos = 2'd3; emit = 1'b1; ne = 1'b1;
						end
						default: begin
							dec = {carry_q[1:0], v[5:0]}; carry = '0;
							pos = 2'd0; emit = 1'b1; ne = 1'b1;
						end
					endcase
				end
			end
			default: ph = cdd_pkg::PH_ERR;
		endcase
		priority if (ph == cdd_pkg::PH_ERR) st = err;
		else if (ph == cdd_pkg::PH_V1_DONE || ph == cdd_pkg::PH_V2_DONE) st = cdd_pkg::ST_OK;
		else if (ph == cdd_pkg::PH_V2_NAME || ph == cdd_pkg::PH_V2_MSG) st = cdd_pkg::ST_NL;
		else st = cdd_pkg::ST_TRUNC;
		slot.has_byte = in_valid && emit;
		slot.dbyte = dec;
		slot.sel = sel;
		slot.has_verdict = in_valid && in_last;
		slot.version = ver;
		slot.status = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cdd_pkg::PH_FLAG; rem_q <= '0; ver_q <= '0; pos_q <= '0;
			carry_q <= '0; pad_q <= 1'b0; ne_q <= 1'b0; err_q <= cdd_pkg::ST_OK;
		end else if (in_valid) begin
			if (in_last) begin
				phase_q <= cdd_pkg::PH_FLAG; rem_q <= '0; ver_q <= '0; pos_q <= '0;
				carry_q <= '0; pad_q <= 1'b0; ne_q <= 1'b0; err_q <= cdd_pkg::ST_OK;
			end else begin
				phase_q <= ph; rem_q <= rem; ver_q <= ver; pos_q <= pos;
				carry_q <= carry; pad_q <= pad; ne_q <= ne; err_q <= err;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		slot.has_byte |-> (ver_q != 2'd0))
		else $error("field byte before version");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_last |=> phase_q == cdd_pkg::PH_FLAG)
		else $error("no return to flag after last");
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == cdd_pkg::PH_ERR |-> err_q != cdd_pkg::ST_OK)
		else $error("error phase without code");
endmodule

// ----- hw/rtl/cdd_queue.sv -----
`timescale 1ns / 1ps
module cdd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cdd_pkg::slot_t push_slot,
	output logic           ready,
	input  logic           pop,
	output logic           not_empty,
	output cdd_pkg::slot_t head
);
	cdd_pkg::slot_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign ready = (cnt_q < 3'd3);
	assign not_empty = (cnt_q != 3'd0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 3'd1)
		else $error("count slip");
endmodule

// ----- hw/rtl/cdd_back.sv -----
`timescale 1ns / 1ps
module cdd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           not_empty,
	input  cdd_pkg::slot_t head,
	output logic           pop,
	output logic           tvalid,
	input  logic           tready,
	output logic [13:0]    tdata,
	output logic           tuser
);
	logic byte_done_q;
	logic need_byte, fire, last_part;

	assign need_byte = head.has_byte && !byte_done_q;
	assign tvalid = not_empty;
	assign tuser = !need_byte;
	assign tdata = need_byte ? {cdd_pkg::ST_OK, head.version, head.sel, head.dbyte}
		: {head.status, head.version, 1'b0, 8'h00};
	assign fire = tvalid && tready;
	assign last_part = !(need_byte && head.has_verdict);
	assign pop = fire && last_part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) byte_done_q <= 1'b0;
		else if (pop) byte_done_q <= 1'b0;
		else if (fire) byte_done_q <= 1'b1;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		byte_done_q |-> not_empty && head.has_verdict)
		else $error("split slot lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		tvalid && !tready |=> tvalid)
		else $error("valid dropped under stall");
endmodule

// ----- hw/rtl/chat_datagram_deframer_top.sv -----
`timescale 1ns / 1ps
// Chat datagram deframer.
// Input stream s_axis: one datagram byte per item, tlast on the final byte.
// Output stream m_axis: decoded name/message bytes (tuser 0) and one verdict
// per datagram (tuser 1), the verdict always the last item of its datagram.
// A front stage parses one byte per cycle while s_axis_tready is high and
// writes at most one slot per byte into a four-entry queue; the back stage
// drains slots to m_axis. A result enters the queue when its byte is accepted.
// Throughput: one input byte per cycle while s_axis_tready is high; a final
// byte that also decodes a field byte yields two output items.
// Reset clears parser state and the queue; the first byte is taken as flag.
// When m_axis stalls the queue fills and s_axis_tready drops once three
// slots are pending; nothing is lost or repeated.
module chat_datagram_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tlast,  // end_of_packet
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // out_byte, field_select, packet_version, status
	output logic        m_axis_tuser   // is_verdict
);
	cdd_pkg::slot_t fslot, head;
	logic acc, push, pop, not_empty;
	logic [13:0] data14;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign push = acc && (fslot.has_byte || fslot.has_verdict);
	assign m_axis_tdata = {2'b00, data14};

	cdd_front u_front (.clk, .arst_n, .in_valid(acc), .in_byte(s_axis_tdata),
		.in_last(s_axis_tlast), .slot(fslot));
	cdd_queue u_queue (.clk, .arst_n, .push, .push_slot(fslot), .ready(s_axis_tready),
		.pop, .not_empty, .head);
	cdd_back u_back (.clk, .arst_n, .not_empty, .head, .pop, .tvalid(m_axis_tvalid),
		.tready(m_axis_tready), .tdata(data14), .tuser(m_axis_tuser));
endmodule

// ----- tb/cdd_checker.sv -----
`timescale 1ns / 1ps
module cdd_checker
	import cdd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	output int          errors,
	output int          pending
);
	typedef struct packed {
		logic       verdict;
		logic [7:0] dbyte;
		logic       sel;
		logic [1:0] version;
		logic [2:0] status;
	} result_t;

	result_t expected_q[$];
	phase_t ph;
	logic [15:0] remaining;
	logic [1:0] version;
	logic [1:0] b64_pos;
	logic [5:0] carry;
	logic pad_seen;
	logic nonempty;
	logic [2:0] err_code;

	assign pending = expected_q.size();

	task automatic report(input string what, input result_t got, input result_t exp);
		$display("mismatch %s: got v%0d b%02h s%0d ver%0d st%0d exp v%0d b%02h s%0d ver%0d st%0d",
			what, got.verdict, got.dbyte, got.sel, got.version, got.status,
			exp.verdict, exp.dbyte, exp.sel, exp.version, exp.status);
		errors++;
	endtask

	function automatic logic [6:0] sextet(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return 7'(c - "A");
		if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
		if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
		if (c == "+") return 7'd62;
		if (c == "/") return 7'd63;
		if (c == "=") return B64_PAD;
		return B64_BAD;
	endfunction

	task automatic clear_line();
		b64_pos = 0;
		carry = 0;
		pad_seen = 0;
		nonempty = 0;
	endtask

	task automatic clear_all();
		ph = PH_FLAG;
		remaining = 0;
		version = 0;
		err_code = ST_OK;
		clear_line();
	endtask

	task automatic fail(input logic [2:0] code);
		err_code = code;
		ph = PH_ERR;
	endtask

	task automatic push_byte(input logic [7:0] b, input logic sel);
		result_t r;
		r = '{verdict: 1'b0, dbyte: b, sel: sel, version: version, status: ST_OK};
		expected_q.push_back(r);
	endtask

	task automatic decode_line_byte(input logic [7:0] c);
		logic [6:0] v;
		logic sel;
		sel = (ph == PH_V2_MSG);
		if (c == NEWLINE) begin
			if (b64_pos != 0) fail(ST_B64);
			else if (!nonempty) fail(ST_EMPTY);
			else begin
				ph = (ph == PH_V2_NAME) ? PH_V2_MSG : PH_V2_DONE;
				clear_line();
			end
			return;
		end
		v = sextet(c);
		if (v == B64_BAD) fail(ST_B64);
		else if (pad_seen) begin
			if (b64_pos == 0 || v != B64_PAD) fail(ST_B64);
			else b64_pos = b64_pos + 1;
		end else if (v == B64_PAD) begin
			if (b64_pos < 2) fail(ST_B64);
			else begin
				pad_seen = 1;
				b64_pos = b64_pos + 1;
			end
		end else begin
			case (b64_pos)
				0: carry = v[5:0];
				1: begin
					push_byte({carry, v[5:4]}, sel);
					carry = {2'b0, v[3:0]};
				end
				2: begin
					push_byte({carry[3:0], v[5:2]}, sel);
					carry = {4'b0, v[1:0]};
				end
				default: begin
					push_byte({carry[1:0], v[5:0]}, sel);
					carry = 0;
				end
			endcase
			if (b64_pos != 0) nonempty = 1;
			b64_pos = b64_pos + 1;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last);
		result_t r;
		case (ph)
			PH_FLAG: if (b != FLAG_BYTE) fail(ST_FLAG); else ph = PH_VER;
			PH_VER: begin
				if (b == VER_ONE) begin
					version = 1;
					ph = PH_NLEN_HI;
				end else if (b == VER_TWO) begin
					version = 2;
					ph = PH_V2_NAME;
					clear_line();
				end else fail(ST_VER);
			end
			PH_NLEN_HI: begin
				remaining = {b, 8'h00};
				ph = PH_NLEN_LO;
			end
			PH_MLEN_HI: begin
				remaining = {b, 8'h00};
				ph = PH_MLEN_LO;
			end
			PH_NLEN_LO: begin
				remaining = remaining | b;
				ph = (remaining != 0) ? PH_NAME : PH_MLEN_HI;
			end
			PH_MLEN_LO: begin
				remaining = remaining | b;
				ph = (remaining != 0) ? PH_MSG : PH_V1_DONE;
			end
			PH_NAME, PH_MSG: begin
				push_byte(b, ph == PH_MSG);
				remaining = remaining - 1;
				if (remaining == 0) ph = (ph == PH_NAME) ? PH_MLEN_HI : PH_V1_DONE;
			end
			PH_V1_DONE, PH_V2_DONE: fail(ST_TRAIL);
			PH_V2_NAME, PH_V2_MSG: decode_line_byte(b);
			default: ph = PH_ERR;
		endcase
		if (last) begin
			r = '{verdict: 1'b1, dbyte: 8'h00, sel: 1'b0, version: version, status: ST_OK};
			if (ph == PH_ERR) r.status = err_code;
			else if (ph == PH_V1_DONE || ph == PH_V2_DONE) r.status = ST_OK;
			else if (ph == PH_V2_NAME || ph == PH_V2_MSG) r.status = ST_NL;
			else r.status = ST_TRUNC;
			expected_q.push_back(r);
			clear_all();
		end
	endtask

	initial begin
		errors = 0;
		clear_all();
	end

	always @(posedge clk) begin
		result_t got;
		result_t exp;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{verdict: m_axis_tuser, dbyte: m_axis_tdata[7:0],
					sel: m_axis_tdata[8], version: m_axis_tdata[10:9],
					status: m_axis_tdata[13:11]};
				if (expected_q.size() == 0) report("unexpected item", got, got);
				else begin
					exp = expected_q.pop_front();
					if (got.verdict !== exp.verdict) report("kind", got, exp);
					else if (got.dbyte !== exp.dbyte) report("byte", got, exp);
					else if (got.sel !== exp.sel) report("field", got, exp);
					else if (got.version !== exp.version) report("version", got, exp);
					else if (got.status !== exp.status) report("status", got, exp);
					else if (m_axis_tdata[15:14] !== 2'b00) report("pad bits", got, exp);
				end
			end
		end
	end
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import cdd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	int          errors;
	int          pending;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_off;
	int          byte_count;
	longint      cycles;
	byte unsigned pkt[$];

	chat_datagram_deframer_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	cdd_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	initial begin
		m_axis_tready = 0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_axis_tready <= 0;
			end else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_packet();
		int i;
		for (i = 0; i < pkt.size(); i++) begin
			while ($urandom_range(99) < send_idle_pct) begin
				s_axis_tvalid <= 0;
				@(posedge clk);
			end
			s_axis_tvalid <= 1;
			s_axis_tdata <= pkt[i];
			s_axis_tlast <= (i == pkt.size() - 1);
			do @(posedge clk); while (!s_axis_tready);
			byte_count++;
		end
	endtask

	task automatic b64_encode(input byte unsigned raw[$], output byte unsigned txt[$]);
		string alpha;
		int i;
		int n;
		logic [23:0] w;
		alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		txt = {};
		for (i = 0; i < raw.size(); i += 3) begin
			n = raw.size() - i;
			w = {raw[i], (n > 1) ? raw[i + 1] : 8'h00, (n > 2) ? raw[i + 2] : 8'h00};
			txt.push_back(alpha[w[23:18]]);
			txt.push_back(alpha[w[17:12]]);
			txt.push_back((n > 1) ? alpha[w[11:6]] : "=");
			txt.push_back((n > 2) ? alpha[w[5:0]] : "=");
		end
	endtask

	task automatic build_v1(input int nlen, input int mlen);
		int i;
		pkt = {8'h01, VER_ONE, 8'(nlen >> 8), 8'(nlen)};
		for (i = 0; i < nlen; i++) pkt.push_back($urandom_range(255));
		pkt.push_back(8'(mlen >> 8));
		pkt.push_back(8'(mlen));
		for (i = 0; i < mlen; i++) pkt.push_back($urandom_range(255));
	endtask

	task automatic build_v2(input int nlen, input int mlen);
		byte unsigned raw[$];
		byte unsigned txt[$];
		int i;
		pkt = {8'h01, VER_TWO};
		raw = {};
		for (i = 0; i < nlen; i++) raw.push_back($urandom_range(255));
		b64_encode(raw, txt);
		pkt = {pkt, txt, NEWLINE};
		raw = {};
		for (i = 0; i < mlen; i++) raw.push_back($urandom_range(255));
		b64_encode(raw, txt);
		pkt = {pkt, txt, NEWLINE};
	endtask

	task automatic mangle();
		int k;
		k = $urandom_range(3);
		if (k == 0 && pkt.size() > 1) pkt = pkt[0:$urandom_range(pkt.size() - 2)];
		else if (k == 1) pkt[$urandom_range(pkt.size() - 1)] = $urandom_range(255);
		else if (k == 2) pkt.push_back($urandom_range(255));
		else pkt[$urandom_range(pkt.size() - 1)] = "=";
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_phase(input int n_bytes);
		int target;
		target = byte_count + n_bytes;
		while (byte_count < target) begin
			if ($urandom_range(9) < 5) build_v1($urandom_range(6), $urandom_range(6));
			else build_v2($urandom_range(1, 7), $urandom_range(1, 7));
			if ($urandom_range(9) < 2) mangle();
			send_packet();
		end
	endtask

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tlast = 0;
		hold_off = 0;
		byte_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// directed: good frames, every error kind, extremes
		build_v1(0, 0); send_packet();
		build_v1(2, 1); pkt[4] = 8'hFF; pkt[5] = 8'h00; send_packet();
		pkt = {8'h00}; send_packet();
		pkt = {8'hFF, 8'h01}; send_packet();
		pkt = {8'h01, 8'h03}; send_packet();
		pkt = {8'h01, 8'hFF, 8'h00}; send_packet();
		pkt = {8'h01}; send_packet();
		pkt = {8'h01, VER_ONE, 8'h01, 8'h00, 8'hAA}; send_packet();
		build_v1(1, 1); pkt.push_back(8'h80); send_packet();
		build_v2(1, 2); send_packet();
		pkt = {8'h01, VER_TWO, "Q", "U", "J", "D"}; send_packet();
		pkt = {8'h01, VER_TWO, "/", "+", "z", "9", NEWLINE, "Q", "Q", "=", "=", NEWLINE};
		send_packet();
		pkt = {8'h01, VER_TWO, "Q", "!", NEWLINE}; send_packet();
		pkt = {8'h01, VER_TWO, "=", "A", NEWLINE}; send_packet();
		pkt = {8'h01, VER_TWO, "Q", "Q", "=", "A", NEWLINE}; send_packet();
		pkt = {8'h01, VER_TWO, "Q", "Q", NEWLINE}; send_packet();
		pkt = {8'h01, VER_TWO, NEWLINE}; send_packet();
		pkt = {8'h01, VER_TWO, "Q", "Q", "=", "=", "Q", NEWLINE}; send_packet();
		build_v2(2, 3); pkt.push_back("A"); send_packet();
		build_v2(1, 1); pkt[$] = 8'h8A; send_packet();

		// sender pauses until every result is in
		wait_drained();

		// long receiver hold-off while sender keeps offering
		hold_off = 60;
		build_v1(20, 20); send_packet();
		wait_drained();

		send_idle_pct = 22; recv_idle_pct = 48;
		random_phase(500);
		send_idle_pct = 48; recv_idle_pct = 22;
		random_phase(500);
		send_idle_pct = 0; recv_idle_pct = 0;
		random_phase(500);

		s_axis_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
